[rtl/amg_pkg.sv]
// ---------------------------------------------------------------------------
// amg_pkg
// Shared constants and types for the adjacency matrix graph store: field
// widths, command codes, edge memory word layout and the control/status
// bundles between the sequencer and the datapath.
// ---------------------------------------------------------------------------
package amg_pkg;

	// default vertex capacity
	localparam int MAX_VERTICES_DEF = 1024;

	// request and result field widths
	localparam int CMD_W  = 2;
	localparam int ID_W   = 10;
	localparam int VCNT_W = 11;
	localparam int ECNT_W = 20;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ADD_VERTEX = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD_EDGE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY      = 2'd2;

	// status codes
	localparam logic STS_OK     = 1'b0;
	localparam logic STS_REJECT = 1'b1;

	// edge memory word layout
	localparam int EWORD_W = 64;
	localparam int EBIT_W  = 6;

	// sequencer to datapath commands
	typedef struct packed {
		logic clear;
		logic load;
		logic rd_a;
		logic rd_b;
		logic eval;
		logic commit;
	} dp_ctl_t;

	// datapath to sequencer status
	typedef struct packed {
		logic clear_last;
		logic slot_free;
	} dp_sts_t;

endpackage

[rtl/adjacency_matrix_graph_store.sv]
// ---------------------------------------------------------------------------
// adjacency_matrix_graph_store
// Undirected graph store: vertex-present memory plus an edge bit memory
// holding one bit per unordered vertex pair. Each request adds a vertex,
// adds an edge or queries adjacency, and returns one result with status,
// adjacency answer and the running vertex and edge counts.
//
// channel   direction  handshake             payload
// request   in         in_valid / in_ready   cmd, first_vertex, second_vertex
// result    out        out_valid / out_ready status, adjacent, vertex_count,
//                                            edge_count
//
// A request steps through accept, two reads of the single vertex memory
// read port, evaluation of the edge word, and commit of the writes.
// Commit waits while an earlier result is still held in the result register.
// After reset a clearing pass writes both memories, one word a cycle, until
// every vertex-present word and edge word is zero; in_ready stays low until
// it ends.
// ---------------------------------------------------------------------------
module adjacency_matrix_graph_store #(
	parameter int MAX_VERTICES = amg_pkg::MAX_VERTICES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [amg_pkg::CMD_W-1:0]   cmd,
	input  logic [amg_pkg::ID_W-1:0]    first_vertex,
	input  logic [amg_pkg::ID_W-1:0]    second_vertex,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        status,
	output logic                        adjacent,
	output logic [amg_pkg::VCNT_W-1:0]  vertex_count,
	output logic [amg_pkg::ECNT_W-1:0]  edge_count
);
	import amg_pkg::*;

	dp_ctl_t ctl;
	dp_sts_t sts;

	// sequencer
	amg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.ctl      (ctl),
		.sts      (sts)
	);

	// datapath
	amg_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.cmd           (cmd),
		.first_vertex  (first_vertex),
		.second_vertex (second_vertex),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.adjacent      (adjacent),
		.vertex_count  (vertex_count),
		.edge_count    (edge_count)
	);

endmodule

[rtl/amg_ram.sv]
// ---------------------------------------------------------------------------
// amg_ram
// Generic single-clock RAM, one write port and one read port, registered
// read data.
// ---------------------------------------------------------------------------
module amg_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[rtl/amg_ctrl.sv]
// ---------------------------------------------------------------------------
// amg_ctrl
// Sequencer for the graph store: runs the clearing pass after reset, then
// steps each request through vertex reads, edge read, evaluation and commit.
// ---------------------------------------------------------------------------
module amg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output amg_pkg::dp_ctl_t ctl,
	input  amg_pkg::dp_sts_t sts
);
	import amg_pkg::*;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_RDA   = 6'b000100,
		ST_RDB   = 6'b001000,
		ST_EVAL  = 6'b010000,
		ST_WRITE = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_RDA;
			end
			ST_RDA:  state_d = ST_RDB;
			ST_RDB:  state_d = ST_EVAL;
			ST_EVAL: state_d = ST_WRITE;
			ST_WRITE: begin
				if (sts.slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// command decode
	assign in_ready   = (state_q == ST_IDLE);
	assign ctl.clear  = (state_q == ST_CLEAR);
	assign ctl.load   = (state_q == ST_IDLE) && in_valid;
	assign ctl.rd_a   = (state_q == ST_RDA);
	assign ctl.rd_b   = (state_q == ST_RDB);
	assign ctl.eval   = (state_q == ST_EVAL);
	assign ctl.commit = (state_q == ST_WRITE) && sts.slot_free;

endmodule

[rtl/amg_dp.sv]
// ---------------------------------------------------------------------------
// amg_dp
// Datapath for the graph store: request registers, vertex-present memory,
// edge bit memory (one bit per unordered vertex pair), running counts and
// the result register.
// ---------------------------------------------------------------------------
module amg_dp #(
	parameter int MAX_VERTICES = amg_pkg::MAX_VERTICES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  amg_pkg::dp_ctl_t            ctl,
	output amg_pkg::dp_sts_t            sts,
	input  logic [amg_pkg::CMD_W-1:0]   cmd,
	input  logic [amg_pkg::ID_W-1:0]    first_vertex,
	input  logic [amg_pkg::ID_W-1:0]    second_vertex,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        status,
	output logic                        adjacent,
	output logic [amg_pkg::VCNT_W-1:0]  vertex_count,
	output logic [amg_pkg::ECNT_W-1:0]  edge_count
);
	import amg_pkg::*;

	localparam int VA_W    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int RW      = ((VA_W > ID_W) ? VA_W : ID_W) + 1;
	localparam int EDEPTH  = (MAX_VERTICES * MAX_VERTICES + EWORD_W - 1) / EWORD_W;
	localparam int EA_W    = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;
	localparam int IDX_W   = EA_W + EBIT_W;
	localparam int CLR_LEN = (EDEPTH > MAX_VERTICES) ? EDEPTH : MAX_VERTICES;
	localparam int CLR_W   = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;

	// request registers
	logic [CMD_W-1:0] cmd_q;
	logic [ID_W-1:0]  a_q;
	logic [ID_W-1:0]  b_q;

	// per-request working registers
	logic [IDX_W-1:0]   edge_idx_q;
	logic               pa_q;
	logic               status_q;
	logic               adj_q;
	logic               vwr_q;
	logic               ewr_q;
	logic [EWORD_W-1:0] ewdata_q;

	// running counts, clear counter, result register
	logic [VCNT_W-1:0] vertex_total_q;
	logic [ECNT_W-1:0] edge_total_q;
	logic [CLR_W-1:0]  clr_cnt_q;
	logic              out_valid_q;
	logic              out_status_q;
	logic              out_adj_q;

	// memory ports
	logic               vram_we;
	logic [VA_W-1:0]    vram_waddr;
	logic               vram_wdata;
	logic [VA_W-1:0]    vram_raddr;
	logic               vram_rdata;
	logic               eram_we;
	logic [EA_W-1:0]    eram_waddr;
	logic [EWORD_W-1:0] eram_wdata;
	logic [EA_W-1:0]    eram_raddr;
	logic [EWORD_W-1:0] eram_rdata;

	// decoded vertex ids
	logic [RW-1:0]      a_wide;
	logic [RW-1:0]      b_wide;
	logic [VA_W-1:0]    a_addr;
	logic [VA_W-1:0]    b_addr;
	logic               a_ok;
	logic               b_ok;
	logic [VA_W-1:0]    lo_addr;
	logic [VA_W-1:0]    hi_addr;
	logic [IDX_W-1:0]   edge_idx;
	logic [EA_W-1:0]    edge_word;
	logic [EBIT_W-1:0]  edge_sel;

	// evaluation
	logic pb;
	logic ebit;
	logic ev_status;
	logic ev_adj;
	logic ev_vwr;
	logic ev_ewr;

	// id range check and memory addresses
	assign a_wide  = RW'(a_q);
	assign b_wide  = RW'(b_q);
	assign a_addr  = a_wide[VA_W-1:0];
	assign b_addr  = b_wide[VA_W-1:0];
	assign a_ok    = a_wide < RW'(MAX_VERTICES);
	assign b_ok    = b_wide < RW'(MAX_VERTICES);
	assign lo_addr = (a_q <= b_q) ? a_addr : b_addr;
	assign hi_addr = (a_q <= b_q) ? b_addr : a_addr;

	// pair index: lower id selects the row
	assign edge_idx  = IDX_W'(lo_addr) * IDX_W'(MAX_VERTICES) + IDX_W'(hi_addr);
	assign edge_word = edge_idx_q[IDX_W-1:EBIT_W];
	assign edge_sel  = edge_idx_q[EBIT_W-1:0];

	// command evaluation
	assign pb   = b_ok && vram_rdata;
	assign ebit = eram_rdata[edge_sel];

	always_comb begin
		ev_status = STS_REJECT;
		ev_adj    = 1'b0;
		ev_vwr    = 1'b0;
		ev_ewr    = 1'b0;
		case (cmd_q)
			CMD_ADD_VERTEX: begin
				if (a_ok) begin
					ev_status = STS_OK;
					ev_vwr    = !pa_q;
				end
			end
			CMD_ADD_EDGE: begin
				if (pa_q && pb && !ebit) begin
					ev_status = STS_OK;
					ev_ewr    = 1'b1;
				end
			end
			CMD_QUERY: begin
				if (pa_q && pb) begin
					ev_status = STS_OK;
					ev_adj    = ebit;
				end
			end
			default: ev_status = STS_REJECT;
		endcase
	end

	// request capture and working registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			a_q   <= first_vertex;
			b_q   <= second_vertex;
		end
		if (ctl.rd_a) begin
			edge_idx_q <= edge_idx;
		end
		if (ctl.rd_b) begin
			pa_q <= a_ok && vram_rdata;
		end
		if (ctl.eval) begin
			status_q <= ev_status;
			adj_q    <= ev_adj;
			ewdata_q <= eram_rdata | (EWORD_W'(1) << edge_sel);
		end
	end

	// write enables need reset so no stray write follows the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vwr_q <= 1'b0;
			ewr_q <= 1'b0;
		end else if (ctl.eval) begin
			vwr_q <= ev_vwr;
			ewr_q <= ev_ewr;
		end
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (ctl.clear) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// memory port muxing: clearing pass or commit
	always_comb begin
		if (ctl.clear) begin
			vram_we    = {1'b0, clr_cnt_q} < (CLR_W + 1)'(MAX_VERTICES);
			vram_waddr = clr_cnt_q[VA_W-1:0];
			vram_wdata = 1'b0;
			eram_we    = {1'b0, clr_cnt_q} < (CLR_W + 1)'(EDEPTH);
			eram_waddr = clr_cnt_q[EA_W-1:0];
			eram_wdata = '0;
		end else begin
			vram_we    = ctl.commit && vwr_q;
			vram_waddr = a_addr;
			vram_wdata = 1'b1;
			eram_we    = ctl.commit && ewr_q;
			eram_waddr = edge_word;
			eram_wdata = ewdata_q;
		end
	end

	assign vram_raddr = ctl.rd_b ? b_addr : a_addr;
	assign eram_raddr = edge_word;

	amg_ram #(
		.WIDTH (1),
		.DEPTH (MAX_VERTICES)
	) u_vram (
		.clk   (clk),
		.we    (vram_we),
		.waddr (vram_waddr),
		.wdata (vram_wdata),
		.raddr (vram_raddr),
		.rdata (vram_rdata)
	);

	amg_ram #(
		.WIDTH (EWORD_W),
		.DEPTH (EDEPTH)
	) u_eram (
		.clk   (clk),
		.we    (eram_we),
		.waddr (eram_waddr),
		.wdata (eram_wdata),
		.raddr (eram_raddr),
		.rdata (eram_rdata)
	);

	// running counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_total_q <= '0;
			edge_total_q   <= '0;
		end else if (ctl.commit) begin
			if (vwr_q) vertex_total_q <= vertex_total_q + 1'b1;
			if (ewr_q) edge_total_q   <= edge_total_q + 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			out_status_q <= status_q;
			out_adj_q    <= adj_q;
		end
	end

	// counts change only at commit, which waits for the result slot
	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign adjacent     = out_adj_q;
	assign vertex_count = vertex_total_q;
	assign edge_count   = edge_total_q;

	assign sts.clear_last = clr_cnt_q == CLR_W'(CLR_LEN - 1);
	assign sts.slot_free  = !out_valid_q || out_ready;

	// checks
	a_edge_inc: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit && ewr_q |=> edge_total_q == ECNT_W'($past(edge_total_q) + 1'b1))
		else $error("edge count did not advance on edge insert");

	a_edge_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.commit |=> $stable(edge_total_q))
		else $error("edge count changed outside commit");

	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctl.commit))
		else $error("result raised without commit");

	a_reject_adj: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_status_q == STS_REJECT) |-> !out_adj_q)
		else $error("rejected request reports adjacency");

	a_no_wr_rd: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_a || ctl.rd_b || ctl.eval |-> !(vram_we || eram_we))
		else $error("memory write during read phase");

endmodule
